// ===== design/nss_pkg.sv =====
// Shared types, constants and codes for the note step sequencer.
`default_nettype none
package nss_pkg;

	localparam int SEQ_DEPTH  = 64;
	localparam int PTR_W      = $clog2(SEQ_DEPTH);
	localparam int LEN_W      = $clog2(SEQ_DEPTH + 1);
	localparam int BANK_DEPTH = 2 * SEQ_DEPTH;
	localparam int BADDR_W    = PTR_W + 1;

	localparam int NOTE_W     = 8;
	localparam int TIME_W     = 32;
	localparam int KNOB_W     = 16;
	localparam int CFG16_W    = 16;
	localparam int PROD_W     = 2 * CFG16_W;
	localparam int ELAP_W     = TIME_W + CFG16_W;
	localparam int STEP_OUT_W = 6;
	localparam int ACT_W      = 2;

	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 16;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	// input item kinds
	localparam logic CMD_KEY    = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE    = 2'd0,
		ACT_ALL_OFF = 2'd1,
		ACT_ONE_ON  = 2'd2
	} key_action_t;

	typedef enum logic [1:0] {
		REG_KNOB_FULL   = 2'd0,
		REG_MAX_NOTE_MS = 2'd1,
		REG_NUM_KEYS    = 2'd2,
		REG_REST_CODE   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADVANCE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CFG16_W-1:0] knob_full;
		logic [CFG16_W-1:0] max_note_ms;
		logic [NOTE_W-1:0]  num_keys;
		logic [NOTE_W-1:0]  rest_code;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic advance;
		logic read;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_update;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/note_step_sequencer_unit.sv =====
// Top level of the note step sequencer: stream ports, APB settings, controller and datapath.
// An item with tuser 0 records the key note in tdata; an item with tuser 1 is an update
// tick and yields one result item. A key item passes through accept and execute; an update
// item passes through accept, bank write and the two note length products, step advance,
// bank read and result load, holding in result load while the previous result still waits
// downstream; the next item is taken back in idle. The extra update steps come from the
// registered multiplies ahead of the note length compare and the registered bank read.
// The result register lets the next item enter while a result still waits downstream.
`default_nettype none
module note_step_sequencer_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// tdata: key_index[7:0], append_switch[8], reset_switch[9], rest_clicked[10],
	//        now_ms[42:11], knob[58:43], zero[63:59]
	input  wire logic [nss_pkg::S_TDATA_W-1:0] s_tdata,
	// tuser: command[0]
	input  wire logic [0:0]                    s_tuser,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// tdata: key_on_index[7:0], led[8], step_index[14:9], playing[15]
	output logic      [nss_pkg::M_TDATA_W-1:0] m_tdata,
	// tuser: key_action[1:0]
	output logic      [nss_pkg::ACT_W-1:0]     m_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nss_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [nss_pkg::PDATA_W-1:0]   pwdata,
	output logic      [nss_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready
);
	import nss_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	nss_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	nss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

endmodule
`default_nettype wire

// ===== design/nss_cfg_regs.sv =====
// APB register file for the note step sequencer settings.
`default_nettype none
module nss_cfg_regs (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [nss_pkg::PADDR_W-1:0] paddr,
	input  wire logic [nss_pkg::PDATA_W-1:0] pwdata,
	output logic      [nss_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output nss_pkg::cfg_t               cfg
);
	import nss_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.knob_full   <= CFG16_W'(1023);
			cfg_q.max_note_ms <= CFG16_W'(1000);
			cfg_q.num_keys    <= NOTE_W'(13);
			cfg_q.rest_code   <= NOTE_W'(255);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KNOB_FULL:   cfg_q.knob_full   <= pwdata[CFG16_W-1:0];
				REG_MAX_NOTE_MS: cfg_q.max_note_ms <= pwdata[CFG16_W-1:0];
				REG_NUM_KEYS:    cfg_q.num_keys    <= pwdata[NOTE_W-1:0];
				REG_REST_CODE:   cfg_q.rest_code   <= pwdata[NOTE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_KNOB_FULL:   prdata = PDATA_W'(cfg_q.knob_full);
			REG_MAX_NOTE_MS: prdata = PDATA_W'(cfg_q.max_note_ms);
			REG_NUM_KEYS:    prdata = PDATA_W'(cfg_q.num_keys);
			REG_REST_CODE:   prdata = PDATA_W'(cfg_q.rest_code);
			default:         prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/nss_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module nss_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  nss_pkg::dp_status_t      status,
	output nss_pkg::ctrl_cmd_t       cmd
);
	import nss_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.is_update ? ST_ADVANCE : ST_IDLE;
			end
			ST_ADVANCE: begin
				cmd.advance = 1'b1;
				state_d     = ST_READ;
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/nss_datapath.sv =====
// Datapath: note banks, sequence state, note length compare and result register.
`default_nettype none
module nss_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  nss_pkg::cfg_t                     cfg,
	input  nss_pkg::ctrl_cmd_t                cmd,
	output nss_pkg::dp_status_t               status,
	input  wire logic [nss_pkg::S_TDATA_W-1:0] in_data,
	input  wire logic [0:0]                   in_user,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [nss_pkg::M_TDATA_W-1:0] out_data,
	output logic      [nss_pkg::ACT_W-1:0]    out_user
);
	import nss_pkg::*;

	// latched item
	logic              cmd_q;
	logic [NOTE_W-1:0] key_q;
	logic              append_q;
	logic              reset_sw_q;
	logic              rest_q;
	logic [TIME_W-1:0] now_q;
	logic [KNOB_W-1:0] knob_q;

	// sequence state
	logic              sel_q;
	logic [LEN_W-1:0]  main_len_q;
	logic [LEN_W-1:0]  temp_len_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              not_started_q;
	logic [TIME_W-1:0] start_ms_q;
	logic              was_resetting_q;
	logic              led_q;
	logic              swap_empty_q;

	logic [PROD_W-1:0] len_prod_s1;
	logic [ELAP_W-1:0] elap_prod_s1;
	logic [NOTE_W-1:0] rd_note_q;
	logic [NOTE_W-1:0] bank_mem [BANK_DEPTH];

	logic [M_TDATA_W-1:0] out_data_q;
	logic [ACT_W-1:0]     out_user_q;
	logic                 out_valid_q;

	// execute-cycle signals
	logic               is_update;
	logic               swap;
	logic               sel_a;
	logic [LEN_W-1:0]   main_len_a;
	logic [LEN_W-1:0]   temp_len_a;
	logic               do_rec;
	logic [NOTE_W-1:0]  rec_note;
	logic               wr_en;
	logic               wr_main;
	logic [BADDR_W-1:0] wr_addr;
	logic [TIME_W-1:0]  elapsed;
	logic [CFG16_W-1:0] div_val;

	// advance-cycle signals
	logic               playing;
	logic               step_due;
	logic [LEN_W-1:0]   ptr_inc;
	logic [PTR_W-1:0]   ptr_next;
	key_action_t        action;

	assign is_update = (cmd_q == CMD_UPDATE);
	assign swap      = is_update & ~reset_sw_q & was_resetting_q;
	assign sel_a      = swap ? ~sel_q : sel_q;
	assign main_len_a = swap ? temp_len_q : main_len_q;
	assign temp_len_a = swap ? '0 : temp_len_q;
	assign do_rec    = is_update ? rest_q : 1'b1;
	assign rec_note  = is_update ? cfg.rest_code : key_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_main = 1'b0;
		wr_addr = '0;
		if (do_rec && append_q) begin
			wr_main = 1'b1;
			wr_en   = (main_len_a < LEN_W'(SEQ_DEPTH));
			wr_addr = {sel_a, main_len_a[PTR_W-1:0]};
		end else if (do_rec && reset_sw_q) begin
			wr_en   = (temp_len_a < LEN_W'(SEQ_DEPTH));
			wr_addr = {~sel_a, temp_len_a[PTR_W-1:0]};
		end
	end

	assign elapsed = now_q - start_ms_q;
	assign div_val = (cfg.knob_full == '0) ? CFG16_W'(1) : cfg.knob_full;

	assign playing  = (main_len_q != '0);
	assign step_due = not_started_q | (elap_prod_s1 > ELAP_W'(len_prod_s1));
	assign ptr_inc  = LEN_W'(ptr_q) + LEN_W'(1);
	assign ptr_next = not_started_q ? '0 :
		(ptr_inc >= main_len_q) ? '0 : ptr_inc[PTR_W-1:0];

	always_comb begin
		if (playing) begin
			action = ACT_ONE_ON;
		end else if (swap_empty_q) begin
			action = ACT_ALL_OFF;
		end else begin
			action = ACT_NONE;
		end
	end

	// hold the item fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_user[0];
			key_q      <= in_data[7:0];
			append_q   <= in_data[8];
			reset_sw_q <= in_data[9];
			rest_q     <= in_data[10];
			now_q      <= in_data[42:11];
			knob_q     <= in_data[58:43];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q           <= 1'b0;
			main_len_q      <= '0;
			temp_len_q      <= '0;
			ptr_q           <= '0;
			not_started_q   <= 1'b1;
			start_ms_q      <= '0;
			was_resetting_q <= 1'b0;
			led_q           <= 1'b0;
			swap_empty_q    <= 1'b0;
		end else if (cmd.exec) begin
			sel_q        <= sel_a;
			main_len_q   <= (wr_en && wr_main) ? main_len_a + LEN_W'(1) : main_len_a;
			temp_len_q   <= (wr_en && !wr_main) ? temp_len_a + LEN_W'(1) : temp_len_a;
			swap_empty_q <= swap && (main_len_a == '0);
			if (is_update) begin
				was_resetting_q <= reset_sw_q;
			end
			if (swap) begin
				not_started_q <= 1'b1;
				ptr_q         <= '0;
				if (main_len_a == '0) begin
					led_q <= 1'b0;
				end
			end
		end else if (cmd.advance && playing && step_due) begin
			ptr_q         <= ptr_next;
			not_started_q <= 1'b0;
			start_ms_q    <= now_q;
			led_q         <= ~led_q;
		end
	end

	// note length compare: elapsed > floor(P/D) exactly when elapsed*D > P
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			len_prod_s1  <= PROD_W'(knob_q) * PROD_W'(cfg.max_note_ms);
			elap_prod_s1 <= ELAP_W'(elapsed) * ELAP_W'(div_val);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			bank_mem[wr_addr] <= rec_note;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_note_q <= bank_mem[{sel_q, ptr_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_user_q <= action;
			out_data_q <= {playing,
				playing ? STEP_OUT_W'(ptr_q) : STEP_OUT_W'(0),
				led_q,
				playing ? rd_note_q : NOTE_W'(0)};
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_data_q;
	assign out_user         = out_user_q;
	assign status.is_update = is_update;
	assign status.out_free  = ~out_valid_q | out_ready;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(main_len_q <= LEN_W'(SEQ_DEPTH)) && (temp_len_q <= LEN_W'(SEQ_DEPTH)))
		else $error("bank length beyond depth");

	a_ptr_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(main_len_q != '0) |-> (LEN_W'(ptr_q) < main_len_q))
		else $error("step pointer outside main sequence");

	a_swap_clears_temp: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sel_q) |-> (temp_len_q <= LEN_W'(1)))
		else $error("temporary bank not emptied on swap");

	a_swap_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sel_q) |-> (not_started_q && (ptr_q == '0)))
		else $error("step not restarted on swap");

endmodule
`default_nettype wire
